FILE: design/yuyv_decimate_to_rgb565_top_assert.svh
// ----------------------------------------------------------------------------
// YUYV decimator assertion macros
// Shared property forms for the checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef YUYV_DECIMATE_TO_RGB565_TOP_ASSERT_SVH
`define YUYV_DECIMATE_TO_RGB565_TOP_ASSERT_SVH

// Same-cycle implication, sampled on aclk, off while in reset
`define YDR_ASSERT_NOW(lbl, cond, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |-> (prop)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk, off while in reset
`define YDR_ASSERT_NEXT(lbl, cond, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |=> (prop)) \
        else $error(msg);

`endif

FILE: design/ydr565_pkg.sv
// ----------------------------------------------------------------------------
// YUYV decimator package
// Frame geometry constants and types shared by the decimator modules.
// ----------------------------------------------------------------------------
package ydr565_pkg;

    localparam int SRC_WIDTH  = 640;
    localparam int OUT_WIDTH  = 480;
    localparam int OUT_HEIGHT = 272;

    // Macropixel counts per row and output row limit
    localparam logic [9:0] MP_PER_SRC_ROW = 10'(SRC_WIDTH / 2);
    localparam logic [8:0] MP_PER_OUT_ROW = 9'(OUT_WIDTH / 2);
    localparam logic [8:0] OUT_ROWS       = 9'(OUT_HEIGHT);

    // Row phases within the group of seven
    localparam logic [2:0] PHASE_DROP_A = 3'd3;
    localparam logic [2:0] PHASE_DROP_B = 3'd6;
    localparam logic [2:0] PHASE_LAST   = 3'd6;
    // Column position within the group of five that is dropped
    localparam logic [2:0] COL_DROP     = 3'd4;

    // Decision for one accepted macropixel
    typedef struct packed {
        logic keep;
        logic done;
    } ydr_decision_t;

    // Two converted pixels of one macropixel
    typedef struct packed {
        logic [15:0] px_even;
        logic [15:0] px_odd;
        logic        done;
    } ydr_pair_t;

endpackage

FILE: design/ydr565_ctrl.sv
// ----------------------------------------------------------------------------
// YUYV decimator control
// Column, row phase and output row counters; decides which macropixels stay.
// ----------------------------------------------------------------------------
module ydr565_ctrl
    import ydr565_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          accept,
    input  logic          frame_start,
    output ydr_decision_t decision
);

    logic [8:0] col_reg,   col_next;
    logic [2:0] mod5_reg,  mod5_next;
    logic [8:0] kept_reg,  kept_next;
    logic [2:0] phase_reg, phase_next;
    logic [8:0] rows_reg,  rows_next;

    logic [8:0] col_cur;
    logic [2:0] mod5_cur;
    logic [8:0] kept_cur;
    logic [2:0] phase_cur;
    logic [8:0] rows_cur;
    logic       row_kept;
    logic       col_kept;

    // Start of frame clears the counters before this macropixel is judged
    always_comb begin
        col_cur   = frame_start ? 9'd0 : col_reg;
        mod5_cur  = frame_start ? 3'd0 : mod5_reg;
        kept_cur  = frame_start ? 9'd0 : kept_reg;
        phase_cur = frame_start ? 3'd0 : phase_reg;
        rows_cur  = frame_start ? 9'd0 : rows_reg;
    end

    // Keep decision and end-of-frame flag
    always_comb begin
        row_kept = (phase_cur != PHASE_DROP_A) && (phase_cur != PHASE_DROP_B)
                   && (rows_cur < OUT_ROWS);
        col_kept = (mod5_cur != COL_DROP) && (kept_cur < MP_PER_OUT_ROW);
        decision.keep = row_kept && col_kept;
        decision.done = ({1'b0, rows_cur} + 10'd1 == {1'b0, OUT_ROWS})
                        && ({1'b0, kept_cur} + 10'd1 == {1'b0, MP_PER_OUT_ROW});
    end

    // Advance counters, wrap at the end of each source row
    always_comb begin
        if ({1'b0, col_cur} + 10'd1 >= MP_PER_SRC_ROW) begin
            col_next   = 9'd0;
            mod5_next  = 3'd0;
            kept_next  = 9'd0;
            rows_next  = row_kept ? rows_cur + 9'd1 : rows_cur;
            phase_next = (phase_cur >= PHASE_LAST) ? 3'd0 : phase_cur + 3'd1;
        end else begin
            col_next   = col_cur + 9'd1;
            mod5_next  = (mod5_cur == COL_DROP) ? 3'd0 : mod5_cur + 3'd1;
            kept_next  = (mod5_cur == COL_DROP) ? kept_cur : kept_cur + 9'd1;
            rows_next  = rows_cur;
            phase_next = phase_cur;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg   <= 9'd0;
            mod5_reg  <= 3'd0;
            kept_reg  <= 9'd0;
            phase_reg <= 3'd0;
            rows_reg  <= 9'd0;
        end else if (accept) begin
            col_reg   <= col_next;
            mod5_reg  <= mod5_next;
            kept_reg  <= kept_next;
            phase_reg <= phase_next;
            rows_reg  <= rows_next;
        end
    end

endmodule

FILE: design/ydr565_lane.sv
// ----------------------------------------------------------------------------
// YUYV decimator colour lane
// Three-stage YUV to RGB565 conversion of one luma sample.
// ----------------------------------------------------------------------------
module ydr565_lane
    import ydr565_pkg::*;
(
    input  logic        aclk,
    input  logic        en,
    input  logic [7:0]  luma,
    input  logic [7:0]  cb,
    input  logic [7:0]  cr,
    output logic [15:0] pixel
);

    logic signed [8:0]  u_s;
    logic signed [8:0]  v_s;
    logic signed [17:0] u_ext;
    logic signed [17:0] v_ext;

    logic [7:0]         y_reg;
    logic signed [17:0] rv_reg, rv_next;
    logic signed [17:0] gu_reg, gu_next;
    logic signed [17:0] gv_reg, gv_next;
    logic signed [17:0] bu_reg, bu_next;

    logic signed [18:0] y_sc;
    logic signed [18:0] r_reg, r_next;
    logic signed [18:0] g_reg, g_next;
    logic signed [18:0] b_reg, b_next;

    logic [15:0] pixel_reg, pixel_next;
    logic [7:0]  r8, g8, b8;

    // Clamp to 0..255 after the arithmetic shift by eight
    function automatic logic [7:0] clamp8(input logic signed [18:0] s);
        logic [7:0] res;
        if (s[18]) begin
            res = 8'd0;
        end else if (|s[17:16]) begin
            res = 8'hFF;
        end else begin
            res = s[15:8];
        end
        return res;
    endfunction

    // Remove chroma offset and form constant products
    always_comb begin
        u_s     = $signed({1'b0, cb}) - 9'sd128;
        v_s     = $signed({1'b0, cr}) - 9'sd128;
        u_ext   = 18'(u_s);
        v_ext   = 18'(v_s);
        rv_next = v_ext * 18'sd359;
        gu_next = u_ext * 18'sd88;
        gv_next = v_ext * 18'sd183;
        bu_next = u_ext * 18'sd454;
    end

    // Add the scaled luma to each channel
    always_comb begin
        y_sc   = $signed({3'b000, y_reg, 8'h00});
        r_next = y_sc + 19'(rv_reg);
        g_next = y_sc - 19'(gu_reg) - 19'(gv_reg);
        b_next = y_sc + 19'(bu_reg);
    end

    // Clamp and pack 5-6-5
    always_comb begin
        r8         = clamp8(r_reg);
        g8         = clamp8(g_reg);
        b8         = clamp8(b_reg);
        pixel_next = {r8[7:3], g8[7:2], b8[7:3]};
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            y_reg     <= luma;
            rv_reg    <= rv_next;
            gu_reg    <= gu_next;
            gv_reg    <= gv_next;
            bu_reg    <= bu_next;
            r_reg     <= r_next;
            g_reg     <= g_next;
            b_reg     <= b_next;
            pixel_reg <= pixel_next;
        end
    end

    assign pixel = pixel_reg;

endmodule

FILE: design/ydr565_merge.sv
// ----------------------------------------------------------------------------
// YUYV decimator merge stage
// Holds the pixel pair from both lanes and sends it as two requests.
// ----------------------------------------------------------------------------
module ydr565_merge
    import ydr565_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    input  ydr_pair_t   in_pair,
    output logic        take,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [15:0] pixel_rgb565
    output logic        m_tlast,
    output logic        m_tuser    // [0] frame_done
);

    typedef enum logic [2:0] {
        MG_EMPTY  = 3'b001,
        MG_FIRST  = 3'b010,
        MG_SECOND = 3'b100
    } mg_state_t;

    mg_state_t state_reg, state_next;
    ydr_pair_t pair_reg;

    // Take a new pair when empty or when the second pixel leaves now
    always_comb begin
        take = (state_reg == MG_EMPTY) || ((state_reg == MG_SECOND) && m_tready);
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            MG_EMPTY: begin
                if (in_valid) state_next = MG_FIRST;
            end
            MG_FIRST: begin
                if (m_tready) state_next = MG_SECOND;
            end
            MG_SECOND: begin
                if (m_tready) state_next = in_valid ? MG_FIRST : MG_EMPTY;
            end
            default: state_next = MG_EMPTY;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= MG_EMPTY;
        end else begin
            state_reg <= state_next;
        end
    end

    // Load the pair on take
    always_ff @(posedge aclk) begin
        if (take && in_valid) begin
            pair_reg <= in_pair;
        end
    end

    // Drive the result channel
    always_comb begin
        m_tvalid = (state_reg != MG_EMPTY);
        m_tlast  = (state_reg == MG_SECOND);
        m_tdata  = (state_reg == MG_SECOND) ? pair_reg.px_odd : pair_reg.px_even;
        m_tuser  = (state_reg == MG_SECOND) && pair_reg.done;
    end

endmodule

FILE: design/yuyv_decimate_to_rgb565_top.sv
// Path: a kept macropixel passes the lane stages and the merge register before its
// first pixel shows; the second shows in the cycle after the first is taken.
// Throughput: a kept macropixel sends both pixels in turn on the single result port;
// dropped macropixels are taken one per cycle while the lane pipeline is not stalled.
// Reset: synchronous aresetn clears counters, valid bits and the merge state.
// ----------------------------------------------------------------------------
// YUYV to RGB565 decimator top level
// Two colour lanes convert both luma samples of a macropixel side by side.
// ----------------------------------------------------------------------------
module yuyv_decimate_to_rgb565_top
    import ydr565_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [7:0] luma_even, [15:8] chroma_blue,
                                   // [23:16] luma_odd, [31:24] chroma_red
    input  logic        s_tuser,   // [0] frame_start
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [15:0] pixel_rgb565
    output logic        m_tlast,   // last_of_pair
    output logic        m_tuser    // [0] frame_done
);

    ydr_decision_t decision;
    ydr_pair_t     pair;
    logic          accept;
    logic          adv;
    logic          take;
    logic          v1_reg, v2_reg, v3_reg;
    logic          d1_reg, d2_reg, d3_reg;
    logic [15:0]   px_even, px_odd;

    // Move the lane pipeline whenever its last stage is free or drained
    assign adv      = !v3_reg || take;
    assign s_tready = adv;
    assign accept   = s_tvalid && adv;

    ydr565_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accept      (accept),
        .frame_start (s_tuser),
        .decision    (decision)
    );

    ydr565_lane u_lane_even (
        .aclk  (aclk),
        .en    (adv),
        .luma  (s_tdata[7:0]),
        .cb    (s_tdata[15:8]),
        .cr    (s_tdata[31:24]),
        .pixel (px_even)
    );

    ydr565_lane u_lane_odd (
        .aclk  (aclk),
        .en    (adv),
        .luma  (s_tdata[23:16]),
        .cb    (s_tdata[15:8]),
        .cr    (s_tdata[31:24]),
        .pixel (px_odd)
    );

    // Track valid and end-of-frame flag alongside the lane stages
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= accept && decision.keep;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            d1_reg <= decision.done;
            d2_reg <= d1_reg;
            d3_reg <= d2_reg;
        end
    end

    assign pair.px_even = px_even;
    assign pair.px_odd  = px_odd;
    assign pair.done    = d3_reg;

    ydr565_merge u_merge (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (v3_reg),
        .in_pair  (pair),
        .take     (take),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    // Checks on pairing and back-pressure
`include "yuyv_decimate_to_rgb565_top_assert.svh"

    `YDR_ASSERT_NEXT(a_pair_second, m_tvalid && m_tready && !m_tlast, m_tvalid && m_tlast, "first pixel not followed by second")
    `YDR_ASSERT_NOW(a_stall_full, !s_tready, m_tvalid && v3_reg, "input stalled with room downstream")
    `YDR_ASSERT_NOW(a_done_last, m_tvalid && m_tuser, m_tlast, "frame_done on first pixel of pair")
    `YDR_ASSERT_NEXT(a_drain_empty, m_tvalid && m_tready && m_tlast && !v3_reg, !m_tvalid, "merge stage not empty after drain")

endmodule
